/* rtl/core/mcsl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mcsl_pkg;

    // Field and datapath widths
    localparam int OFFSET_BITS = 40;
    localparam int DIM_W       = 15;
    localparam int DEPTH_W     = 12;
    localparam int CNT_W       = 4;
    localparam int SLICE_W     = 11;
    localparam int ARRAY_W     = 12;
    localparam int KIND_W      = 2;
    localparam int ES_W        = 8;
    localparam int PITCH_W     = 20;
    localparam int PITCH_OUT_W = 19;
    localparam int ROWS_W      = 15;
    localparam int SURF_W      = 33;
    localparam int STATUS_W    = 2;
    localparam int ACC_W       = 47;
    localparam int MPLIER_W    = 15;
    localparam int CFG_W       = 15;
    localparam int REG_IDX_W   = 3;

    // Size limits
    localparam logic [DIM_W-1:0]   MAX_DIMENSION = 15'd16384;
    localparam logic [ARRAY_W-1:0] MAX_SLICES    = 12'd2048;

    // Commands
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_NEXT    = 1'b1;

    // Result status
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FINISHED = 2'd2;

    // Format kinds
    localparam logic [KIND_W-1:0] KIND_LINEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BC     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PACKED = 2'd2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_BASE_WIDTH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BASE_HEIGHT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BASE_DEPTH   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIP_COUNT    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KEPT_MIPS    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ARRAY_COUNT  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FORMAT_KIND  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ELEMENT_SIZE = 3'd7;

    typedef struct packed {
        logic                   cmd;
        logic [OFFSET_BITS-1:0] available_bytes;
    } t_in_item;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] byte_offset;
        logic [PITCH_OUT_W-1:0] row_pitch;
        logic [ROWS_W-1:0]      row_count;
        logic [SURF_W-1:0]      surface_bytes;
        logic                   kept;
        logic [STATUS_W-1:0]    status;
        logic                   last;
    } t_out_item;

    typedef struct packed {
        logic [DIM_W-1:0]   base_width;
        logic [DIM_W-1:0]   base_height;
        logic [DEPTH_W-1:0] base_depth;
        logic [KIND_W-1:0]  format_kind;
        logic [ES_W-1:0]    element_size;
    } t_geom_cfg;

    typedef struct packed {
        logic               linear;
        logic [DIM_W-1:0]   pitch_mcand;
        logic [ES_W-1:0]    pitch_mplier;
        logic [ROWS_W-1:0]  rows;
        logic [DEPTH_W-1:0] depth;
    } t_geom;

    typedef struct packed {
        logic                start;
        logic [ACC_W-1:0]    mcand;
        logic [MPLIER_W-1:0] mplier;
        logic [ACC_W-1:0]    init;
    } t_mul_req;

endpackage
`default_nettype wire

/* rtl/core/mcsl_geom.sv */
`timescale 1ns / 1ps
`default_nettype none
module mcsl_geom (
    input  wire logic                       i_clk,
    input  wire logic                       i_load,
    input  wire mcsl_pkg::t_geom_cfg        i_cfg,
    input  wire logic [mcsl_pkg::CNT_W-1:0] i_mip,
    output mcsl_pkg::t_geom                 o_geom
);

    logic [mcsl_pkg::DIM_W-1:0]   w0, wc, ws, w;
    logic [mcsl_pkg::DIM_W-1:0]   h0, hc, hs, h;
    logic [mcsl_pkg::DEPTH_W-1:0] d0, ds, d;
    logic [mcsl_pkg::DIM_W:0]     w_up4, w_up2, h_up4;
    mcsl_pkg::t_geom              n_geom;
    mcsl_pkg::t_geom              r_geom;

    // Clamp the base size and scale it down to the current mip
    always_comb begin
        w0 = (i_cfg.base_width == '0) ? mcsl_pkg::DIM_W'(1) : i_cfg.base_width;
        wc = (w0 > mcsl_pkg::MAX_DIMENSION) ? mcsl_pkg::MAX_DIMENSION : w0;
        ws = wc >> i_mip;
        w  = (ws == '0) ? mcsl_pkg::DIM_W'(1) : ws;

        h0 = (i_cfg.base_height == '0) ? mcsl_pkg::DIM_W'(1) : i_cfg.base_height;
        hc = (h0 > mcsl_pkg::MAX_DIMENSION) ? mcsl_pkg::MAX_DIMENSION : h0;
        hs = hc >> i_mip;
        h  = (hs == '0) ? mcsl_pkg::DIM_W'(1) : hs;

        d0 = (i_cfg.base_depth == '0) ? mcsl_pkg::DEPTH_W'(1) : i_cfg.base_depth;
        ds = d0 >> i_mip;
        d  = (ds == '0) ? mcsl_pkg::DEPTH_W'(1) : ds;

        w_up4 = {1'b0, w} + (mcsl_pkg::DIM_W+1)'(3);
        w_up2 = {1'b0, w} + (mcsl_pkg::DIM_W+1)'(1);
        h_up4 = {1'b0, h} + (mcsl_pkg::DIM_W+1)'(3);
    end

    // Pick the pitch product operands for the format kind
    always_comb begin
        n_geom.depth = d;
        case (i_cfg.format_kind)
            mcsl_pkg::KIND_BC: begin
                n_geom.linear       = 1'b0;
                n_geom.pitch_mcand  = mcsl_pkg::DIM_W'(w_up4 >> 2);
                n_geom.pitch_mplier = i_cfg.element_size;
                n_geom.rows         = mcsl_pkg::ROWS_W'(h_up4 >> 2);
            end
            mcsl_pkg::KIND_PACKED: begin
                n_geom.linear       = 1'b0;
                n_geom.pitch_mcand  = mcsl_pkg::DIM_W'(w_up2 >> 1);
                n_geom.pitch_mplier = mcsl_pkg::ES_W'(4);
                n_geom.rows         = h;
            end
            default: begin
                n_geom.linear       = 1'b1;
                n_geom.pitch_mcand  = w;
                n_geom.pitch_mplier = i_cfg.element_size;
                n_geom.rows         = h;
            end
        endcase
    end

    // Hold the operands for the whole walk step
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_geom <= n_geom;
        end
    end

    assign o_geom = r_geom;

endmodule
`default_nettype wire

/* rtl/core/mcsl_serial_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
module mcsl_serial_mul (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mcsl_pkg::t_mul_req         i_req,
    output logic                            o_done,
    output logic [mcsl_pkg::ACC_W-1:0]      o_acc
);

    logic                              r_busy, n_busy;
    logic [mcsl_pkg::ACC_W-1:0]        r_acc, n_acc;
    logic [mcsl_pkg::ACC_W-1:0]        r_mcand, n_mcand;
    logic [mcsl_pkg::MPLIER_W-1:0]     r_mplier, n_mplier;

    // Finish once the multiplier shift register has run empty
    assign o_done = r_busy && (r_mplier == '0);
    assign o_acc  = r_acc;

    // One multiplier bit per cycle: add the shifted multiplicand, advance both
    always_comb begin
        n_busy   = r_busy;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        if (i_req.start) begin
            n_busy   = 1'b1;
            n_acc    = i_req.init;
            n_mcand  = i_req.mcand;
            n_mplier = i_req.mplier;
        end else if (r_busy) begin
            if (r_mplier == '0) begin
                n_busy = 1'b0;
            end else begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

endmodule
`default_nettype wire

/* rtl/core/mip_chain_surface_layout_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_ready      i_in  (mcsl_pkg::t_in_item)
// out       output     o_out_valid / i_out_ready    o_out (mcsl_pkg::t_out_item)
// cfg       input      i_cfg_we                     i_cfg_idx, i_cfg_wdata
//
// A restart transfer gives no result. A next transfer holds the input while one
// shift-add multiplier, one multiplier bit per cycle, forms pitch (element size
// bits), surface (row count bits), then the advanced offset (depth bits), through
// the GEOM, PITCH, SURF, ADV and DONE states. A next on a stopped walk goes straight
// to DONE and gives a finished result. Reset is synchronous, active low, and leaves
// the walk stopped. A stalled output holds its result while the next item is taken;
// that item's result then waits in its last cycle until the output register frees.
module mip_chain_surface_layout_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire mcsl_pkg::t_in_item                 i_in,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output mcsl_pkg::t_out_item                     o_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [mcsl_pkg::REG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [mcsl_pkg::CFG_W-1:0]         i_cfg_wdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GEOM  = 3'd1;
    localparam logic [2:0] S_PITCH = 3'd2;
    localparam logic [2:0] S_SURF  = 3'd3;
    localparam logic [2:0] S_ADV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Configuration registers
    logic [mcsl_pkg::DIM_W-1:0]   r_base_width, r_base_height;
    logic [mcsl_pkg::DEPTH_W-1:0] r_base_depth;
    logic [mcsl_pkg::CNT_W-1:0]   r_mip_count, r_kept_mips;
    logic [mcsl_pkg::ARRAY_W-1:0] r_array_count;
    logic [mcsl_pkg::KIND_W-1:0]  r_format_kind;
    logic [mcsl_pkg::ES_W-1:0]    r_element_size;

    // Walk state
    logic [2:0]                       r_state, n_state;
    logic [mcsl_pkg::OFFSET_BITS-1:0] r_limit;
    logic [mcsl_pkg::OFFSET_BITS-1:0] r_offset;
    logic [mcsl_pkg::CNT_W-1:0]       r_mip;
    logic [mcsl_pkg::SLICE_W-1:0]     r_slice;
    logic                             r_stopped;
    logic                             r_fin;

    // Step results
    logic [mcsl_pkg::PITCH_W-1:0] r_pitch;
    logic [mcsl_pkg::SURF_W-1:0]  r_surf;
    logic [mcsl_pkg::ACC_W-1:0]   r_next;

    logic                r_out_valid;
    mcsl_pkg::t_out_item r_out, n_out;

    mcsl_pkg::t_geom_cfg geom_cfg;
    mcsl_pkg::t_geom     geom;
    mcsl_pkg::t_mul_req  mul_req;
    logic                mul_done;
    logic [mcsl_pkg::ACC_W-1:0] mul_acc;

    logic                          in_xfer, geom_load, out_free;
    logic [mcsl_pkg::PITCH_W-1:0]  pitch_val;
    logic [mcsl_pkg::CNT_W-1:0]    mips;
    logic [mcsl_pkg::ARRAY_W-1:0]  slices;
    logic                          mip_end, slice_end, is_last, overflow;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign geom_load   = in_xfer && (i_in.cmd == mcsl_pkg::CMD_NEXT) && !r_stopped;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign geom_cfg.base_width   = r_base_width;
    assign geom_cfg.base_height  = r_base_height;
    assign geom_cfg.base_depth   = r_base_depth;
    assign geom_cfg.format_kind  = r_format_kind;
    assign geom_cfg.element_size = r_element_size;

    mcsl_geom u_geom (
        .i_clk  (i_clk),
        .i_load (geom_load),
        .i_cfg  (geom_cfg),
        .i_mip  (r_mip),
        .o_geom (geom)
    );

    mcsl_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_acc   (mul_acc)
    );

    // Linear pitch rounds bits up to whole bytes
    assign pitch_val = geom.linear ? mul_acc[mcsl_pkg::PITCH_W+2:3]
                                   : mul_acc[mcsl_pkg::PITCH_W-1:0];

    // Feed the shared multiplier for each product in turn
    always_comb begin
        mul_req.start  = 1'b0;
        mul_req.mcand  = mcsl_pkg::ACC_W'(geom.pitch_mcand);
        mul_req.mplier = mcsl_pkg::MPLIER_W'(geom.pitch_mplier);
        mul_req.init   = geom.linear ? mcsl_pkg::ACC_W'(7) : '0;
        case (r_state)
            S_GEOM: begin
                mul_req.start = 1'b1;
            end
            S_PITCH: begin
                mul_req.start  = mul_done;
                mul_req.mcand  = mcsl_pkg::ACC_W'(pitch_val);
                mul_req.mplier = geom.rows;
                mul_req.init   = '0;
            end
            S_SURF: begin
                mul_req.start  = mul_done;
                mul_req.mcand  = mcsl_pkg::ACC_W'(mul_acc[mcsl_pkg::SURF_W-1:0]);
                mul_req.mplier = mcsl_pkg::MPLIER_W'(geom.depth);
                mul_req.init   = mcsl_pkg::ACC_W'(r_offset);
            end
            default: begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    // Level and walk ends, overflow check
    always_comb begin
        mips = (r_mip_count == '0) ? mcsl_pkg::CNT_W'(1) : r_mip_count;
        if (r_array_count == '0) begin
            slices = mcsl_pkg::ARRAY_W'(1);
        end else if (r_array_count > mcsl_pkg::MAX_SLICES) begin
            slices = mcsl_pkg::MAX_SLICES;
        end else begin
            slices = r_array_count;
        end
        mip_end   = ({1'b0, r_mip} + (mcsl_pkg::CNT_W+1)'(1)) >= {1'b0, mips};
        slice_end = ({1'b0, r_slice} + mcsl_pkg::ARRAY_W'(1)) >= slices;
        is_last   = mip_end && slice_end;
        overflow  = r_next > mcsl_pkg::ACC_W'(r_limit);
    end

    // Build the result
    always_comb begin
        n_out = '0;
        if (r_fin) begin
            n_out.status = mcsl_pkg::ST_FINISHED;
        end else begin
            n_out.byte_offset   = r_offset;
            n_out.row_pitch     = r_pitch[mcsl_pkg::PITCH_W-1] ? '1
                                : r_pitch[mcsl_pkg::PITCH_OUT_W-1:0];
            n_out.row_count     = geom.rows;
            n_out.surface_bytes = r_surf;
            n_out.kept          = (r_mip < r_kept_mips);
            n_out.last          = is_last;
            n_out.status        = overflow ? mcsl_pkg::ST_OVERFLOW : mcsl_pkg::ST_OK;
        end
    end

    // Sequence one walk step
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_in.cmd == mcsl_pkg::CMD_NEXT)) begin
                    n_state = r_stopped ? S_DONE : S_GEOM;
                end
            end
            S_GEOM:  n_state = S_PITCH;
            S_PITCH: if (mul_done) n_state = S_SURF;
            S_SURF:  if (mul_done) n_state = S_ADV;
            S_ADV:   if (mul_done) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_base_width   <= mcsl_pkg::DIM_W'(1);
            r_base_height  <= mcsl_pkg::DIM_W'(1);
            r_base_depth   <= mcsl_pkg::DEPTH_W'(1);
            r_mip_count    <= mcsl_pkg::CNT_W'(1);
            r_kept_mips    <= mcsl_pkg::CNT_W'(1);
            r_array_count  <= mcsl_pkg::ARRAY_W'(1);
            r_format_kind  <= mcsl_pkg::KIND_LINEAR;
            r_element_size <= mcsl_pkg::ES_W'(32);
            r_limit        <= '0;
            r_offset       <= '0;
            r_mip          <= '0;
            r_slice        <= '0;
            r_stopped      <= 1'b1;
            r_fin          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            // Take configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mcsl_pkg::REG_BASE_WIDTH:   r_base_width   <= i_cfg_wdata;
                    mcsl_pkg::REG_BASE_HEIGHT:  r_base_height  <= i_cfg_wdata;
                    mcsl_pkg::REG_BASE_DEPTH:   r_base_depth   <= i_cfg_wdata[mcsl_pkg::DEPTH_W-1:0];
                    mcsl_pkg::REG_MIP_COUNT:    r_mip_count    <= i_cfg_wdata[mcsl_pkg::CNT_W-1:0];
                    mcsl_pkg::REG_KEPT_MIPS:    r_kept_mips    <= i_cfg_wdata[mcsl_pkg::CNT_W-1:0];
                    mcsl_pkg::REG_ARRAY_COUNT:  r_array_count  <= i_cfg_wdata[mcsl_pkg::ARRAY_W-1:0];
                    mcsl_pkg::REG_FORMAT_KIND:  r_format_kind  <= i_cfg_wdata[mcsl_pkg::KIND_W-1:0];
                    mcsl_pkg::REG_ELEMENT_SIZE: r_element_size <= i_cfg_wdata[mcsl_pkg::ES_W-1:0];
                    default: ;
                endcase
            end

            // Restart or open a step
            if (in_xfer) begin
                if (i_in.cmd == mcsl_pkg::CMD_RESTART) begin
                    r_limit   <= i_in.available_bytes;
                    r_offset  <= '0;
                    r_mip     <= '0;
                    r_slice   <= '0;
                    r_stopped <= 1'b0;
                end else begin
                    r_fin <= r_stopped;
                end
            end

            // Post the result when the step closes, else drain the output register
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // Close the step: advance the walk
            if ((r_state == S_DONE) && out_free) begin
                if (!r_fin) begin
                    if (overflow) begin
                        r_stopped <= 1'b1;
                    end else begin
                        r_offset <= r_next[mcsl_pkg::OFFSET_BITS-1:0];
                        if (is_last) begin
                            r_stopped <= 1'b1;
                        end else if (mip_end) begin
                            r_mip   <= '0;
                            r_slice <= r_slice + mcsl_pkg::SLICE_W'(1);
                        end else begin
                            r_mip <= r_mip + mcsl_pkg::CNT_W'(1);
                        end
                    end
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_PITCH) && mul_done) begin
            r_pitch <= pitch_val;
        end
        if ((r_state == S_SURF) && mul_done) begin
            r_surf <= mul_acc[mcsl_pkg::SURF_W-1:0];
        end
        if ((r_state == S_ADV) && mul_done) begin
            r_next <= mul_acc;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

/* tb/sv/mip_chain_surface_layout_unit_test.sv */
`timescale 1ns / 1ps
module mip_chain_surface_layout_unit_test;
    import mcsl_pkg::*;

    localparam int          HALF_PERIOD   = 5;
    localparam int          RESET_CYCLES  = 11;
    localparam int          DRAIN_CYCLES  = 64;
    localparam int          RANDOM_ITEMS  = 850;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam longint unsigned PITCH_CAP = (64'd1 << PITCH_OUT_W) - 1;
    localparam longint unsigned ROWS_CAP  = (64'd1 << ROWS_W) - 1;

    // One texture layout as written to the register file
    typedef struct {
        int unsigned width;
        int unsigned height;
        int unsigned depth;
        int unsigned mips;
        int unsigned kept;
        int unsigned slices;
        int unsigned kind;
        int unsigned esize;
    } t_layout;

    // Tracks the walk state and the descriptors still owed by the block
    class layout_walk_tracker;
        logic [DIM_W-1:0]   base_width;
        logic [DIM_W-1:0]   base_height;
        logic [DEPTH_W-1:0] base_depth;
        logic [CNT_W-1:0]   mip_count;
        logic [CNT_W-1:0]   kept_mips;
        logic [ARRAY_W-1:0] array_count;
        logic [KIND_W-1:0]  format_kind;
        logic [ES_W-1:0]    element_size;
        longint unsigned    byte_limit;
        longint unsigned    running_offset;
        logic [CNT_W-1:0]   mip_index;
        logic [SLICE_W-1:0] slice_index;
        bit                 stopped;
        t_out_item          pending_descriptors[$];
        int unsigned        errors;

        function new();
            base_width     = DIM_W'(1);
            base_height    = DIM_W'(1);
            base_depth     = DEPTH_W'(1);
            mip_count      = CNT_W'(1);
            kept_mips      = CNT_W'(1);
            array_count    = ARRAY_W'(1);
            format_kind    = KIND_LINEAR;
            element_size   = ES_W'(32);
            byte_limit     = 0;
            running_offset = 0;
            mip_index      = '0;
            slice_index    = '0;
            stopped        = 1'b1;
            errors         = 0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_BASE_WIDTH:   base_width   = value[DIM_W-1:0];
                REG_BASE_HEIGHT:  base_height  = value[DIM_W-1:0];
                REG_BASE_DEPTH:   base_depth   = value[DEPTH_W-1:0];
                REG_MIP_COUNT:    mip_count    = value[CNT_W-1:0];
                REG_KEPT_MIPS:    kept_mips    = value[CNT_W-1:0];
                REG_ARRAY_COUNT:  array_count  = value[ARRAY_W-1:0];
                REG_FORMAT_KIND:  format_kind  = value[KIND_W-1:0];
                REG_ELEMENT_SIZE: element_size = value[ES_W-1:0];
                default: ;
            endcase
        endfunction

        // Size of one dimension at a mip level: zero acts as one, clamp, shift, floor of one
        function int unsigned mip_dim(int unsigned base, int unsigned level, int unsigned cap);
            int unsigned b;
            b = (base == 0) ? 1 : base;
            if (b > cap) b = cap;
            b = b >> level;
            return (b == 0) ? 1 : b;
        endfunction

        function int unsigned outstanding();
            return pending_descriptors.size();
        endfunction

        // Work out the descriptor that an accepted request gives, and advance the walk
        function void note_request(t_in_item item);
            t_out_item       d;
            int unsigned     mips, slices, w, h, dep;
            longint unsigned pitch, rows, surf, advanced;
            bit              is_last;

            if (item.cmd == CMD_RESTART) begin
                byte_limit     = item.available_bytes;
                running_offset = 0;
                mip_index      = '0;
                slice_index    = '0;
                stopped        = 1'b0;
                return;
            end

            d = '0;
            if (stopped) begin
                d.status = ST_FINISHED;
                pending_descriptors.push_back(d);
                return;
            end

            mips   = (mip_count == 0) ? 1 : mip_count;
            slices = (array_count == 0) ? 1 : array_count;
            if (slices > MAX_SLICES) slices = MAX_SLICES;

            w   = mip_dim(base_width, mip_index, MAX_DIMENSION);
            h   = mip_dim(base_height, mip_index, MAX_DIMENSION);
            dep = mip_dim(base_depth, mip_index, (1 << DEPTH_W) - 1);

            case (format_kind)
                KIND_BC: begin
                    pitch = 64'((w + 3) / 4) * element_size;
                    rows  = (h + 3) / 4;
                end
                KIND_PACKED: begin
                    pitch = 64'((w + 1) >> 1) * 4;
                    rows  = h;
                end
                default: begin
                    pitch = (64'(w) * element_size + 7) / 8;
                    rows  = h;
                end
            endcase
            surf = pitch * rows;

            is_last = (mip_index + 1 >= mips) && (slice_index + 1 >= slices);

            d.byte_offset   = running_offset[OFFSET_BITS-1:0];
            d.row_pitch     = PITCH_OUT_W'((pitch > PITCH_CAP) ? PITCH_CAP : pitch);
            d.row_count     = ROWS_W'((rows > ROWS_CAP) ? ROWS_CAP : rows);
            d.surface_bytes = surf[SURF_W-1:0];
            d.kept          = (mip_index < kept_mips);
            d.last          = is_last;

            // Report the offending subresource, then stop without advancing
            advanced = running_offset + surf * dep;
            if (advanced > byte_limit) begin
                d.status = ST_OVERFLOW;
                stopped  = 1'b1;
                pending_descriptors.push_back(d);
                return;
            end

            d.status       = ST_OK;
            running_offset = advanced;
            if (is_last) begin
                stopped = 1'b1;
            end else if (mip_index + 1 >= mips) begin
                mip_index   = '0;
                slice_index = slice_index + SLICE_W'(1);
            end else begin
                mip_index = mip_index + CNT_W'(1);
            end
            pending_descriptors.push_back(d);
        endfunction

        function void compare_field(string field, logic [OFFSET_BITS-1:0] want,
                                    logic [OFFSET_BITS-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        // Match a descriptor from the block against the oldest one owed
        function void check_descriptor(t_out_item got);
            t_out_item want;
            if (pending_descriptors.size() == 0) begin
                $error("descriptor with none pending: offset %0d status %0d",
                       got.byte_offset, got.status);
                errors++;
                return;
            end
            want = pending_descriptors.pop_front();
            compare_field("byte_offset", want.byte_offset, got.byte_offset);
            compare_field("row_pitch", want.row_pitch, got.row_pitch);
            compare_field("row_count", want.row_count, got.row_count);
            compare_field("surface_bytes", want.surface_bytes, got.surface_bytes);
            compare_field("kept", want.kept, got.kept);
            compare_field("status", want.status, got.status);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_item;
    logic                 cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0] cfg_idx   = REG_BASE_WIDTH;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int unsigned          in_idle_pct  = 25;
    int unsigned          out_idle_pct = 25;
    int unsigned          cycle_count  = 0;
    layout_walk_tracker   walk = new();

    mip_chain_surface_layout_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Stall the output side at random
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Check every output transfer
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            walk.check_descriptor(out_item);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Write one register; the caller lowers the write enable after the last one
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        walk.set_reg(idx, value[CFG_W-1:0]);
    endtask

    task automatic load_layout(input t_layout l);
        write_reg(REG_BASE_WIDTH, l.width);
        write_reg(REG_BASE_HEIGHT, l.height);
        write_reg(REG_BASE_DEPTH, l.depth);
        write_reg(REG_MIP_COUNT, l.mips);
        write_reg(REG_KEPT_MIPS, l.kept);
        write_reg(REG_ARRAY_COUNT, l.slices);
        write_reg(REG_FORMAT_KIND, l.kind);
        write_reg(REG_ELEMENT_SIZE, l.esize);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one request, idling at random first, and hold it until the transfer
    task automatic send_request(input logic cmd, input logic [OFFSET_BITS-1:0] avail);
        t_in_item item;
        item.cmd             = cmd;
        item.available_bytes = avail;
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        walk.note_request(item);
    endtask

    // Drop valid, wait for every owed descriptor, then let a restart or a walk step finish
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (walk.outstanding() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [OFFSET_BITS-1:0] random_limit();
        longint unsigned v;
        int unsigned     nbits;
        if ($urandom_range(1) == 0) return {OFFSET_BITS{1'b1}};
        v     = {$urandom, $urandom};
        nbits = $urandom_range(OFFSET_BITS);
        return OFFSET_BITS'(v & ((64'd1 << nbits) - 1));
    endfunction

    function automatic int unsigned random_dim();
        case ($urandom_range(9))
            0:       return 0;
            1:       return MAX_DIMENSION;
            2:       return $urandom_range((1 << DIM_W) - 1);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    // Mostly small textures, now and then an extreme
    function automatic t_layout random_layout();
        t_layout l;
        l.width  = random_dim();
        l.height = random_dim();
        case ($urandom_range(19))
            0:       l.depth = 0;
            1:       l.depth = (1 << DEPTH_W) - 1;
            2:       l.depth = $urandom_range((1 << DEPTH_W) - 1);
            3, 4, 5, 6, 7: l.depth = $urandom_range(1, 8);
            default: l.depth = 1;
        endcase
        l.mips = $urandom_range((1 << CNT_W) - 1);
        l.kept = $urandom_range((1 << CNT_W) - 1);
        case ($urandom_range(19))
            0:       l.slices = 0;
            1:       l.slices = MAX_SLICES;
            2:       l.slices = (1 << ARRAY_W) - 1;
            3:       l.slices = $urandom_range((1 << ARRAY_W) - 1);
            default: l.slices = $urandom_range(1, 6);
        endcase
        l.kind = $urandom_range((1 << KIND_W) - 1);
        case ($urandom_range(9))
            0:       l.esize = 0;
            1:       l.esize = (1 << ES_W) - 1;
            2, 3, 4: l.esize = 8 << $urandom_range(4);
            default: l.esize = $urandom_range(1, 128);
        endcase
        return l;
    endfunction

    initial begin
        t_layout     l;
        int unsigned sent;
        int unsigned walk_len;
        int unsigned steps;
        int unsigned mips_eff;
        int unsigned slices_eff;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk is stopped out of reset; a one-texel walk overflows on a zero limit
        send_request(CMD_NEXT, '0);
        send_request(CMD_RESTART, '0);
        send_request(CMD_NEXT, '0);
        send_request(CMD_NEXT, '0);
        send_request(CMD_RESTART, {OFFSET_BITS{1'b1}});
        send_request(CMD_NEXT, '0);
        settle();

        // Largest block-compressed surface: the row pitch saturates
        load_layout('{MAX_DIMENSION, MAX_DIMENSION, 1, 15, 15, 1, KIND_BC, 255});
        send_request(CMD_RESTART, {OFFSET_BITS{1'b1}});
        repeat (3) send_request(CMD_NEXT, {OFFSET_BITS{1'b1}});
        settle();

        // Zero sizes and counts act as one, oversized width clamps, unused kind, no element size
        load_layout('{(1 << DIM_W) - 1, 0, 0, 0, 0, 0, 3, 0});
        send_request(CMD_RESTART, '0);
        send_request(CMD_NEXT, '0);
        send_request(CMD_NEXT, '0);
        settle();

        // Packed volume with too many slices, walking every mip of the first slice
        load_layout('{7, 5, (1 << DEPTH_W) - 1, 4, 2, (1 << ARRAY_W) - 1, KIND_PACKED, 1});
        send_request(CMD_RESTART, {OFFSET_BITS{1'b1}});
        repeat (4) send_request(CMD_NEXT, '0);
        settle();

        // Wide linear volume, two slices, walk past the end
        load_layout('{MAX_DIMENSION, 1, MAX_SLICES, 2, 1, 2, KIND_LINEAR, 255});
        send_request(CMD_RESTART, {1'b1, {(OFFSET_BITS - 1){1'b0}}});
        repeat (5) send_request(CMD_NEXT, '0);
        settle();

        // Random walks: mostly restart then steps, with some noise and unrestarted phases
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= 300 && sent < 500) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct  = 25;
                out_idle_pct = 25;
            end
            l = random_layout();
            load_layout(l);
            if ($urandom_range(9) != 0) begin
                send_request(CMD_RESTART, random_limit());
                sent++;
            end
            mips_eff   = (l.mips == 0) ? 1 : l.mips;
            slices_eff = (l.slices == 0) ? 1 : l.slices;
            if (slices_eff > MAX_SLICES) slices_eff = MAX_SLICES;
            walk_len = mips_eff * slices_eff;
            steps    = ((walk_len > 30) ? 30 : walk_len) + $urandom_range(2);
            repeat (steps) begin
                if ($urandom_range(9) == 0) begin
                    send_request(1'($urandom_range(1)), OFFSET_BITS'({$urandom, $urandom}));
                end else begin
                    send_request(CMD_NEXT, OFFSET_BITS'({$urandom, $urandom}));
                end
                sent++;
            end
            settle();
        end

        if (walk.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/mcsl_pkg.sv
rtl/core/mcsl_geom.sv
rtl/core/mcsl_serial_mul.sv
rtl/core/mip_chain_surface_layout_unit.sv
tb/sv/mip_chain_surface_layout_unit_test.sv
